FILE: sv/tclw_pkg.sv
// Shared types, codes and microprogram for the text console line writer.
package tclw_pkg;

    localparam int COL_W      = 8;
    localparam int LINE_OUT_W = 5;
    localparam int HGT_W      = 9;
    localparam int DROP_W     = 16;
    localparam int PC_W       = 4;
    localparam int OP_W       = 4;
    localparam int COND_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_CFG_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 1'd1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] LEAD_MIN = 8'h81;

    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_CLAMP   = 4'd1;
    localparam logic [OP_W-1:0] OP_PRE     = 4'd2;
    localparam logic [OP_W-1:0] OP_CHWRAP  = 4'd3;
    localparam logic [OP_W-1:0] OP_CHEMIT  = 4'd4;
    localparam logic [OP_W-1:0] OP_TRAIL   = 4'd5;
    localparam logic [OP_W-1:0] OP_NEWLINE = 4'd6;
    localparam logic [OP_W-1:0] OP_TAB     = 4'd7;
    localparam logic [OP_W-1:0] OP_POST    = 4'd8;
    localparam logic [OP_W-1:0] OP_FINISH  = 4'd9;

    localparam logic [COND_W-1:0] C_NEXT    = 3'd0;
    localparam logic [COND_W-1:0] C_JUMP    = 3'd1;
    localparam logic [COND_W-1:0] C_TRAIL   = 3'd2;
    localparam logic [COND_W-1:0] C_NL      = 3'd3;
    localparam logic [COND_W-1:0] C_TAB     = 3'd4;
    localparam logic [COND_W-1:0] C_TABMORE = 3'd5;

    localparam logic [PC_W-1:0] L_TRAIL = 4'd7;
    localparam logic [PC_W-1:0] L_NL    = 4'd8;
    localparam logic [PC_W-1:0] L_TAB   = 4'd9;
    localparam logic [PC_W-1:0] L_POST  = 4'd10;
    localparam logic [PC_W-1:0] L_END   = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic              fin;
    } t_uword;

    typedef struct packed {
        logic trail;
        logic is_nl;
        logic is_tab;
        logic tab_more;
    } t_status;

    typedef struct packed {
        logic                  en;
        logic                  valid;
        logic [LINE_OUT_W-1:0] line;
        logic [COL_W-1:0]      col;
        logic [7:0]            data;
    } t_emit;

    function automatic t_uword mk(logic [OP_W-1:0] op, logic [COND_W-1:0] cond,
                                  logic [PC_W-1:0] target, logic fin);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.fin    = fin;
        return w;
    endfunction

    function automatic t_uword ucode(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = mk(OP_CLAMP,   C_NEXT,    4'd0,    1'b0);
            4'd1:    w = mk(OP_PRE,     C_NEXT,    4'd0,    1'b0);
            4'd2:    w = mk(OP_NOP,     C_TRAIL,   L_TRAIL, 1'b0);
            4'd3:    w = mk(OP_NOP,     C_NL,      L_NL,    1'b0);
            4'd4:    w = mk(OP_NOP,     C_TAB,     L_TAB,   1'b0);
            4'd5:    w = mk(OP_CHWRAP,  C_NEXT,    4'd0,    1'b0);
            4'd6:    w = mk(OP_CHEMIT,  C_JUMP,    L_POST,  1'b0);
            L_TRAIL: w = mk(OP_TRAIL,   C_JUMP,    L_POST,  1'b0);
            L_NL:    w = mk(OP_NEWLINE, C_JUMP,    L_END,   1'b0);
            L_TAB:   w = mk(OP_TAB,     C_TABMORE, L_TAB,   1'b0);
            L_POST:  w = mk(OP_POST,    C_NEXT,    4'd0,    1'b0);
            L_END:   w = mk(OP_FINISH,  C_NEXT,    4'd0,    1'b1);
            default: w = mk(OP_NOP,     C_JUMP,    L_END,   1'b0);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/tclw_sequencer.sv
// Microprogram counter, control store lookup and conditional jumps.
module tclw_sequencer
    import tclw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_status           i_status,
    output logic [OP_W-1:0]   o_op,
    output logic              o_busy,
    output logic              o_done
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_run;
    t_uword          w;
    logic            take;

    assign w = ucode(r_pc);

    always_comb begin
        case (w.cond)
            C_NEXT:    take = 1'b0;
            C_JUMP:    take = 1'b1;
            C_TRAIL:   take = i_status.trail;
            C_NL:      take = i_status.is_nl;
            C_TAB:     take = i_status.is_tab;
            C_TABMORE: take = i_status.tab_more;
            default:   take = 1'b0;
        endcase
        n_pc = take ? w.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_pc  <= '0;
        end else if (r_run) begin
            if (w.fin) begin
                r_run <= 1'b0;
            end else begin
                r_pc <= n_pc;
            end
        end
    end

    assign o_op   = r_run ? w.op : OP_NOP;
    assign o_busy = r_run;
    assign o_done = r_run & w.fin;

endmodule

FILE: sv/tclw_datapath.sv
// Cursor, ring and drop-count registers driven by the microcode operation.
module tclw_datapath
    import tclw_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 32,
    parameter int TAB_STOP    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [7:0]            i_byte,
    input  logic                  i_eos,
    input  logic [OP_W-1:0]       i_op,
    input  logic [COL_W-1:0]      i_line_width,
    input  logic [CNT_CFG_W-1:0]  i_line_count,
    input  logic                  i_buf_empty,
    output t_status               o_status,
    output t_emit                 o_emit,
    output logic [LINE_OUT_W-1:0] o_ring_top,
    output logic [DROP_W-1:0]     o_dropped
);

    localparam int LW  = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;
    localparam int PHW = $clog2(TAB_STOP);

    logic [7:0]        r_byte;
    logic              r_eos;
    logic [LW-1:0]     r_line,    n_line;
    logic [COL_W-1:0]  r_col,     n_col;
    logic [PHW-1:0]    r_phase,   n_phase;
    logic [LW-1:0]     r_oldest,  n_oldest;
    logic [DROP_W-1:0] r_dropped, n_dropped;
    logic              r_swallow, n_swallow;
    logic              r_trail,   n_trail;

    logic [COL_W-1:0]  eff_w;
    logic [HGT_W-1:0]  eff_h;
    logic [HGT_W-1:0]  adv_line;
    logic [HGT_W-1:0]  adv_oldest;
    logic              adv_hit;
    logic              do_adv;
    logic              col_inc;
    logic              wide;
    logic [COL_W:0]    col_w_sum;
    logic [HGT_W-1:0]  line_ext;

    always_comb begin
        if (i_line_width < COL_W'(2)) begin
            eff_w = COL_W'(2);
        end else if (i_line_width > COL_W'(MAX_COLUMNS)) begin
            eff_w = COL_W'(MAX_COLUMNS);
        end else begin
            eff_w = i_line_width;
        end
        if (i_line_count < CNT_CFG_W'(2)) begin
            eff_h = HGT_W'(2);
        end else if (HGT_W'(i_line_count) > HGT_W'(MAX_LINES)) begin
            eff_h = HGT_W'(MAX_LINES);
        end else begin
            eff_h = HGT_W'(i_line_count);
        end
    end

    always_comb begin
        adv_line = HGT_W'(r_line) + HGT_W'(1);
        if (adv_line >= eff_h) begin
            adv_line = '0;
        end
        adv_hit    = (adv_line == HGT_W'(r_oldest));
        adv_oldest = HGT_W'(r_oldest) + HGT_W'(1);
        if (adv_oldest >= eff_h) begin
            adv_oldest = '0;
        end
    end

    assign wide      = (r_byte >= LEAD_MIN);
    assign col_w_sum = {1'b0, r_col} + (wide ? (COL_W + 1)'(2) : (COL_W + 1)'(1));
    assign line_ext  = HGT_W'(r_line);

    always_comb begin
        n_line    = r_line;
        n_col     = r_col;
        n_phase   = r_phase;
        n_oldest  = r_oldest;
        n_dropped = r_dropped;
        n_swallow = r_swallow;
        n_trail   = r_trail;
        do_adv    = 1'b0;
        col_inc   = 1'b0;
        o_emit.en    = 1'b0;
        o_emit.valid = 1'b1;
        o_emit.line  = line_ext[LINE_OUT_W-1:0];
        o_emit.col   = r_col;
        o_emit.data  = r_byte;
        case (i_op)
            OP_CLAMP: begin
                if (HGT_W'(r_oldest) >= eff_h) begin
                    n_oldest = '0;
                end
                if (HGT_W'(r_line) >= eff_h) begin
                    n_line = '0;
                end
            end
            OP_PRE: begin
                do_adv = (r_col >= eff_w);
            end
            OP_CHWRAP: begin
                n_swallow = 1'b0;
                do_adv    = (r_col != '0) && (col_w_sum >= {1'b0, eff_w});
            end
            OP_CHEMIT: begin
                o_emit.en = 1'b1;
                col_inc   = 1'b1;
                n_trail   = wide & ~r_eos;
            end
            OP_TRAIL: begin
                n_trail   = 1'b0;
                n_swallow = 1'b0;
                o_emit.en = 1'b1;
                col_inc   = 1'b1;
            end
            OP_NEWLINE: begin
                if (r_swallow) begin
                    n_swallow = 1'b0;
                end else begin
                    do_adv = 1'b1;
                end
            end
            OP_TAB: begin
                n_swallow   = 1'b0;
                o_emit.en   = 1'b1;
                o_emit.data = CH_SPACE;
                col_inc     = 1'b1;
            end
            OP_POST: begin
                if (!r_trail) begin
                    if (r_col >= eff_w) begin
                        do_adv    = 1'b1;
                        n_swallow = ~r_eos;
                    end else if (r_eos) begin
                        o_emit.en   = 1'b1;
                        o_emit.data = CH_NUL;
                    end
                end
            end
            OP_FINISH: begin
                if (r_eos) begin
                    n_swallow = 1'b0;
                end
                if (i_buf_empty) begin
                    o_emit.en    = 1'b1;
                    o_emit.valid = 1'b0;
                    o_emit.line  = '0;
                    o_emit.col   = '0;
                    o_emit.data  = CH_NUL;
                end
            end
            default: begin
            end
        endcase
        if (do_adv) begin
            o_emit.en   = 1'b1;
            o_emit.data = CH_NUL;
            n_col       = '0;
            n_phase     = '0;
            n_line      = adv_line[LW-1:0];
            if (adv_hit) begin
                n_oldest = adv_oldest[LW-1:0];
                if (r_dropped != {DROP_W{1'b1}}) begin
                    n_dropped = r_dropped + DROP_W'(1);
                end
            end
        end else if (col_inc) begin
            n_col   = r_col + COL_W'(1);
            n_phase = (r_phase == PHW'(TAB_STOP - 1)) ? '0 : r_phase + PHW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line    <= '0;
            r_col     <= '0;
            r_phase   <= '0;
            r_oldest  <= '0;
            r_dropped <= '0;
            r_swallow <= 1'b0;
            r_trail   <= 1'b0;
        end else begin
            r_line    <= n_line;
            r_col     <= n_col;
            r_phase   <= n_phase;
            r_oldest  <= n_oldest;
            r_dropped <= n_dropped;
            r_swallow <= n_swallow;
            r_trail   <= n_trail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_byte <= i_byte;
            r_eos  <= i_eos;
        end
    end

    logic [HGT_W-1:0] oldest_ext;
    assign oldest_ext = HGT_W'(r_oldest);

    assign o_status.trail    = r_trail;
    assign o_status.is_nl    = (r_byte == CH_NL);
    assign o_status.is_tab   = (r_byte == CH_TAB);
    assign o_status.tab_more = ({1'b0, r_col} + (COL_W + 1)'(1) < {1'b0, eff_w})
                             && (r_phase != PHW'(TAB_STOP - 1));
    assign o_ring_top = oldest_ext[LINE_OUT_W-1:0];
    assign o_dropped  = r_dropped;

endmodule

FILE: sv/text_console_line_writer.sv
// Top level: stream ports, configuration registers, result buffer and output register.
//
// Input stream: one text byte per transfer on tdata[7:0]; tlast marks the
// last byte of a string. Output stream: one buffer write per transfer;
// tlast marks the final result caused by one input byte, tuser is the
// write-valid flag. Configuration: i_cfg_we writes line width (index 0) or
// line count (index 1); write only while the block is idle.
// Each byte runs a short microprogram, one step per cycle: 6 steps for a
// newline or trail byte, 9 for a printable byte, 7 plus one per space for a
// tab. Steps append writes to a small result buffer; when the program ends,
// the buffer drains at one result per cycle into the output register, so
// ring_top and lines_dropped carry the values after the whole byte.
// The next byte is taken once draining is done, even while the last result
// still waits in the output register.
// A stalled receiver holds the output register and pauses draining.
// Reset clears the cursor, ring, drop count and flags and sets the line width
// to 64 and the line count to 32.
module text_console_line_writer
    import tclw_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 32,
    parameter int TAB_STOP    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // text_byte
    input  logic                  i_s_axis_tlast,  // end_of_string
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // write_line[4:0], write_column[12:5], write_data[20:13], ring_top[25:21],
    // lines_dropped[41:26], zero fill[47:42]
    output logic [47:0]           o_m_axis_tdata,
    output logic                  o_m_axis_tuser,  // write_valid
    output logic                  o_m_axis_tlast,  // last_result
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int BUF_DEPTH = TAB_STOP + 2;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int BCNT_W    = $clog2(BUF_DEPTH + 1);

    logic [COL_W-1:0]     r_line_width;
    logic [CNT_CFG_W-1:0] r_line_count;

    logic                  accept;
    logic                  seq_busy;
    logic                  seq_done;
    logic [OP_W-1:0]       op;
    t_status               status;
    t_emit                 emit;
    logic [LINE_OUT_W-1:0] ring_top;
    logic [DROP_W-1:0]     dropped;

    t_emit             r_buf [BUF_DEPTH];
    logic [BCNT_W-1:0] r_wr_cnt;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_drain;
    logic              load_out;
    logic              rd_last;
    t_emit             rd_entry;

    logic                  r_ovalid;
    logic [LINE_OUT_W-1:0] r_out_line;
    logic [COL_W-1:0]      r_out_col;
    logic [7:0]            r_out_data;
    logic                  r_out_wvalid;
    logic [LINE_OUT_W-1:0] r_out_top;
    logic [DROP_W-1:0]     r_out_dropped;
    logic                  r_out_last;

    assign o_s_axis_tready = ~seq_busy & ~r_drain;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= COL_W'(64);
            r_line_count <= CNT_CFG_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LINE_WIDTH: r_line_width <= i_cfg_wdata;
                REG_LINE_COUNT: r_line_count <= i_cfg_wdata[CNT_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tclw_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_status (status),
        .o_op     (op),
        .o_busy   (seq_busy),
        .o_done   (seq_done)
    );

    tclw_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES),
        .TAB_STOP    (TAB_STOP)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept),
        .i_byte       (i_s_axis_tdata),
        .i_eos        (i_s_axis_tlast),
        .i_op         (op),
        .i_line_width (r_line_width),
        .i_line_count (r_line_count),
        .i_buf_empty  (r_wr_cnt == '0),
        .o_status     (status),
        .o_emit       (emit),
        .o_ring_top   (ring_top),
        .o_dropped    (dropped)
    );

    assign rd_entry = r_buf[r_rd_idx];
    assign rd_last  = (BCNT_W'(r_rd_idx) + BCNT_W'(1) == r_wr_cnt);
    assign load_out = r_drain & (~r_ovalid | i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (emit.en) begin
            r_buf[r_wr_cnt[IDX_W-1:0]] <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_cnt <= '0;
            r_rd_idx <= '0;
            r_drain  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_wr_cnt <= '0;
            end else if (emit.en) begin
                r_wr_cnt <= r_wr_cnt + BCNT_W'(1);
            end
            if (seq_done) begin
                r_drain  <= 1'b1;
                r_rd_idx <= '0;
            end else if (load_out) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
                if (rd_last) begin
                    r_drain <= 1'b0;
                end
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_line    <= rd_entry.line;
            r_out_col     <= rd_entry.col;
            r_out_data    <= rd_entry.data;
            r_out_wvalid  <= rd_entry.valid;
            r_out_top     <= ring_top;
            r_out_dropped <= dropped;
            r_out_last    <= rd_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'd0, r_out_dropped, r_out_top, r_out_data, r_out_col, r_out_line};
    assign o_m_axis_tuser  = r_out_wvalid;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_cnt <= BCNT_W'(BUF_DEPTH))
        else $error("result buffer overfilled");

    a_done_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |=> (r_wr_cnt != '0))
        else $error("byte finished without any result");

    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (BCNT_W'(r_rd_idx) < r_wr_cnt))
        else $error("drain reads past the written results");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_busy |-> !r_drain)
        else $error("program running while results drain");
`endif

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the text console line writer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tclw_pkg::*;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_LINES   = 32;
    localparam int TAB_STOP    = 4;

    typedef struct {
        logic [4:0]  line;
        logic [7:0]  col;
        logic [7:0]  data;
        logic        valid;
        logic [4:0]  top;
        logic [15:0] dropped;
        logic        last;
    } t_wr_op;

    class t_line_write_board;
        logic [7:0]  width_reg;
        logic [5:0]  count_reg;
        logic [4:0]  cur_line;
        logic [4:0]  top_line;
        logic [7:0]  cur_col;
        logic [15:0] drops;
        bit          swallow_nl;
        bit          trail_due;
        int          wid;
        int          hgt;
        t_wr_op      writes_q[$];
        t_wr_op      batch[$];
        int          errors;
        int          bytes_seen;
        int          writes_seen;

        function new();
            width_reg   = 8'd64;
            count_reg   = 6'd32;
            cur_line    = '0;
            top_line    = '0;
            cur_col     = '0;
            drops       = '0;
            swallow_nl  = 1'b0;
            trail_due   = 1'b0;
            errors      = 0;
            bytes_seen  = 0;
            writes_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == REG_LINE_WIDTH) begin
                width_reg = val;
            end else begin
                count_reg = val[5:0];
            end
        endfunction

        function int pending();
            return writes_q.size();
        endfunction

        function void put(logic [7:0] data);
            t_wr_op w;
            w.line    = cur_line;
            w.col     = cur_col;
            w.data    = data;
            w.valid   = 1'b1;
            w.top     = '0;
            w.dropped = '0;
            w.last    = 1'b0;
            batch.push_back(w);
        endfunction

        function void next_line();
            put(CH_NUL);
            cur_col = '0;
            if (int'(cur_line) + 1 >= hgt) cur_line = '0;
            else cur_line = cur_line + 1'b1;
            if (cur_line == top_line) begin
                if (drops != 16'hFFFF) drops = drops + 1'b1;
                if (int'(top_line) + 1 >= hgt) top_line = '0;
                else top_line = top_line + 1'b1;
            end
        endfunction

        function void note_input(logic [7:0] b, logic eos);
            bit     after_char;
            bit     wide;
            t_wr_op w;
            after_char = 1'b0;
            batch.delete();
            bytes_seen++;
            wid = (width_reg < 2) ? 2 : ((width_reg > MAX_COLUMNS) ? MAX_COLUMNS : width_reg);
            hgt = (count_reg < 2) ? 2 : ((count_reg > MAX_LINES) ? MAX_LINES : count_reg);

            if (top_line >= hgt) top_line = '0;
            if (cur_line >= hgt) cur_line = '0;
            if (cur_col >= wid) next_line();

            if (trail_due) begin
                trail_due  = 1'b0;
                swallow_nl = 1'b0;
                put(b);
                cur_col    = cur_col + 1'b1;
                after_char = 1'b1;
            end else if (b == CH_NL) begin
                if (swallow_nl) swallow_nl = 1'b0;
                else next_line();
            end else if (b == CH_TAB) begin
                swallow_nl = 1'b0;
                do begin
                    put(CH_SPACE);
                    cur_col = cur_col + 1'b1;
                end while (cur_col < wid && (cur_col % TAB_STOP) != 0);
                after_char = 1'b1;
            end else begin
                wide       = (b >= LEAD_MIN);
                swallow_nl = 1'b0;
                if (cur_col != 0 && int'(cur_col) + (wide ? 2 : 1) >= wid) next_line();
                put(b);
                cur_col = cur_col + 1'b1;
                if (wide && !eos) trail_due = 1'b1;
                after_char = 1'b1;
            end

            if (after_char && !trail_due) begin
                if (cur_col >= wid) begin
                    next_line();
                    swallow_nl = !eos;
                end else if (eos) begin
                    put(CH_NUL);
                end
            end
            if (eos) swallow_nl = 1'b0;

            if (batch.size() == 0) begin
                put(CH_NUL);
                batch[0].valid = 1'b0;
                batch[0].line  = '0;
                batch[0].col   = '0;
            end
            for (int k = 0; k < batch.size(); k++) begin
                w         = batch[k];
                w.top     = top_line;
                w.dropped = drops;
                w.last    = (k == batch.size() - 1);
                writes_q.push_back(w);
            end
        endfunction

        function void cmp(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(logic [47:0] td, logic tu, logic tl);
            t_wr_op w;
            if (writes_q.size() == 0) begin
                $error("buffer write with no expected write: tdata %h", td);
                errors++;
                return;
            end
            w = writes_q.pop_front();
            writes_seen++;
            cmp("write_line",    w.line,    td[4:0]);
            cmp("write_column",  w.col,     td[12:5]);
            cmp("write_data",    w.data,    td[20:13]);
            cmp("write_valid",   w.valid,   tu);
            cmp("ring_top",      w.top,     td[25:21]);
            cmp("lines_dropped", w.dropped, td[41:26]);
            cmp("last_result",   w.last,    tl);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [7:0]            s_data = '0;
    logic                  s_last = 1'b0;
    logic                  m_ready = 1'b1;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [47:0]           o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    t_line_write_board board;
    bit  calm = 1'b0;
    bit  quiet = 1'b0;
    int  stall_left = 0;
    int  sent = 0;
    int  configs = 0;

    text_console_line_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("** text_console_line_writer: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            board.check(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
    end

    function automatic int pick_gap();
        if (quiet || calm) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(1, 17);
        return 0;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CH_NL;
        if (r < 20) return CH_TAB;
        if (r < 35) return 8'($urandom_range(LEAD_MIN, 255));
        if (r < 85) return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eos;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_input(b, eos);
        sent++;
        if (sent % 16 == 0) calm = ($urandom_range(0, 2) == 0);
    endtask

    task automatic set_config(input logic [7:0] w, input logic [7:0] h);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_LINE_WIDTH;
        cfg_data <= w;
        @(posedge i_clk);
        cfg_addr <= REG_LINE_COUNT;
        cfg_data <= h;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        board.set_reg(REG_LINE_WIDTH, w);
        board.set_reg(REG_LINE_COUNT, h);
        configs++;
    endtask

    initial begin
        int phase_w [7];
        int phase_h [7];
        int phase_n [7];
        phase_w = '{20, 128, 3, 255, 0, 2, 64};
        phase_h = '{32, 6, 2, 0, 1, 63, 32};
        phase_n = '{35, 30, 25, 25, 20, 25, 28};
        board = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(8'd64, 8'd32);
        send_byte("H", 1'b0);
        send_byte("i", 1'b1);
        send_byte(CH_NL, 1'b1);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_TAB, 1'b1);
        send_byte(8'h81, 1'b0);
        send_byte(CH_NL, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);

        set_config(8'd8, 8'd4);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte("z", 1'b1);

        set_config(8'd2, 8'd2);
        send_byte("k", 1'b1);

        for (int p = 0; p < 7; p++) begin
            if (p == 6) quiet = 1'b1;
            set_config(8'(phase_w[p]), 8'(phase_h[p]));
            for (int i = 0; i < phase_n[p]; i++)
                send_byte(pick_byte(), 1'($urandom_range(0, 6) == 0));
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);

        $display("Checked %0d buffer writes caused by %0d text bytes over %0d line geometries,",
                 board.writes_seen, board.bytes_seen, configs);
        $display("including wraps, tabs, two-column characters and shrunk line rings.");
        if (board.errors == 0) begin
            $display("** text_console_line_writer: PASSED **");
        end else begin
            $display("** text_console_line_writer: FAILED **");
        end
        $finish;
    end

endmodule
